### design/barycentric_texcoord_interp_top_assert.svh
// Assertion macros used by the checker file
`ifndef BARYCENTRIC_TEXCOORD_INTERP_TOP_ASSERT_SVH
`define BARYCENTRIC_TEXCOORD_INTERP_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BTI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is asserted
`define BTI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/bti_pkg.sv
package bti_pkg;

    // parameter defaults
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 32;

    // port field widths
    localparam int FIELD_W = 32;
    localparam int OP_W    = 3;

    // input op codes
    localparam logic [2:0] OP_CORNER0 = 3'd0;
    localparam logic [2:0] OP_CORNER2 = 3'd2;
    localparam logic [2:0] OP_TEX0    = 3'd3;
    localparam logic [2:0] OP_TEX2    = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;

    // item kinds after classification
    localparam logic [1:0] KIND_CORNER = 2'd0;
    localparam logic [1:0] KIND_TEX    = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] idx;
    } bti_cls_t;

    // operand sources of the shared multiplier
    localparam logic [4:0] SRC_B1X = 5'd0;
    localparam logic [4:0] SRC_B1Y = 5'd1;
    localparam logic [4:0] SRC_B1Z = 5'd2;
    localparam logic [4:0] SRC_B2X = 5'd3;
    localparam logic [4:0] SRC_B2Y = 5'd4;
    localparam logic [4:0] SRC_B2Z = 5'd5;
    localparam logic [4:0] SRC_VX  = 5'd6;
    localparam logic [4:0] SRC_VY  = 5'd7;
    localparam logic [4:0] SRC_VZ  = 5'd8;
    localparam logic [4:0] SRC_D12 = 5'd9;
    localparam logic [4:0] SRC_L1  = 5'd10;
    localparam logic [4:0] SRC_L2  = 5'd11;
    localparam logic [4:0] SRC_DV1 = 5'd12;
    localparam logic [4:0] SRC_DV2 = 5'd13;
    localparam logic [4:0] SRC_U1  = 5'd14;
    localparam logic [4:0] SRC_U2  = 5'd15;
    localparam logic [4:0] SRC_W0  = 5'd16;
    localparam logic [4:0] SRC_T0X = 5'd17;
    localparam logic [4:0] SRC_T0Y = 5'd18;
    localparam logic [4:0] SRC_T0Z = 5'd19;
    localparam logic [4:0] SRC_T1X = 5'd20;
    localparam logic [4:0] SRC_T1Y = 5'd21;
    localparam logic [4:0] SRC_T1Z = 5'd22;
    localparam logic [4:0] SRC_T2X = 5'd23;
    localparam logic [4:0] SRC_T2Y = 5'd24;
    localparam logic [4:0] SRC_T2Z = 5'd25;

    // destinations of a finished sum of products
    localparam logic [3:0] DST_D12 = 4'd0;
    localparam logic [3:0] DST_L1  = 4'd1;
    localparam logic [3:0] DST_L2  = 4'd2;
    localparam logic [3:0] DST_DV1 = 4'd3;
    localparam logic [3:0] DST_DV2 = 4'd4;
    localparam logic [3:0] DST_NUM = 4'd5;
    localparam logic [3:0] DST_DEN = 4'd6;
    localparam logic [3:0] DST_TMP = 4'd7;
    localparam logic [3:0] DST_T0  = 4'd8;
    localparam logic [3:0] DST_T1  = 4'd9;
    localparam logic [3:0] DST_T2  = 4'd10;

    // program landmarks
    localparam logic [4:0] STEP_DEN_LAST  = 5'd18;
    localparam logic [4:0] STEP_U2D12     = 5'd19;
    localparam logic [4:0] STEP_TEX_FIRST = 5'd20;
    localparam logic [4:0] STEP_LAST      = 5'd28;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic       first;
        logic       neg;
        logic       last;
        logic [3:0] dest;
    } bti_uop_t;

    function automatic bti_uop_t bti_uop(input logic [4:0] a, input logic [4:0] b,
                                         input logic f, input logic n, input logic l,
                                         input logic [3:0] d);
        bti_uop_t u;
        u.src_a = a;
        u.src_b = b;
        u.first = f;
        u.neg   = n;
        u.last  = l;
        u.dest  = d;
        return u;
    endfunction

    // multiply-accumulate program of one query
    function automatic bti_uop_t bti_prog(input logic [4:0] step);
        bti_uop_t u;
        case (step)
            5'd0:  u = bti_uop(SRC_B1X, SRC_B2X, 1'b1, 1'b0, 1'b0, DST_D12);
            5'd1:  u = bti_uop(SRC_B1Y, SRC_B2Y, 1'b0, 1'b0, 1'b0, DST_D12);
            5'd2:  u = bti_uop(SRC_B1Z, SRC_B2Z, 1'b0, 1'b0, 1'b1, DST_D12);
            5'd3:  u = bti_uop(SRC_B1X, SRC_B1X, 1'b1, 1'b0, 1'b0, DST_L1);
            5'd4:  u = bti_uop(SRC_B1Y, SRC_B1Y, 1'b0, 1'b0, 1'b0, DST_L1);
            5'd5:  u = bti_uop(SRC_B1Z, SRC_B1Z, 1'b0, 1'b0, 1'b1, DST_L1);
            5'd6:  u = bti_uop(SRC_B2X, SRC_B2X, 1'b1, 1'b0, 1'b0, DST_L2);
            5'd7:  u = bti_uop(SRC_B2Y, SRC_B2Y, 1'b0, 1'b0, 1'b0, DST_L2);
            5'd8:  u = bti_uop(SRC_B2Z, SRC_B2Z, 1'b0, 1'b0, 1'b1, DST_L2);
            5'd9:  u = bti_uop(SRC_VX,  SRC_B1X, 1'b1, 1'b0, 1'b0, DST_DV1);
            5'd10: u = bti_uop(SRC_VY,  SRC_B1Y, 1'b0, 1'b0, 1'b0, DST_DV1);
            5'd11: u = bti_uop(SRC_VZ,  SRC_B1Z, 1'b0, 1'b0, 1'b1, DST_DV1);
            5'd12: u = bti_uop(SRC_VX,  SRC_B2X, 1'b1, 1'b0, 1'b0, DST_DV2);
            5'd13: u = bti_uop(SRC_VY,  SRC_B2Y, 1'b0, 1'b0, 1'b0, DST_DV2);
            5'd14: u = bti_uop(SRC_VZ,  SRC_B2Z, 1'b0, 1'b0, 1'b1, DST_DV2);
            5'd15: u = bti_uop(SRC_DV1, SRC_D12, 1'b1, 1'b0, 1'b0, DST_NUM);
            5'd16: u = bti_uop(SRC_DV2, SRC_L1,  1'b0, 1'b1, 1'b1, DST_NUM);
            5'd17: u = bti_uop(SRC_D12, SRC_D12, 1'b1, 1'b0, 1'b0, DST_DEN);
            5'd18: u = bti_uop(SRC_L1,  SRC_L2,  1'b0, 1'b1, 1'b1, DST_DEN);
            5'd19: u = bti_uop(SRC_U2,  SRC_D12, 1'b1, 1'b0, 1'b1, DST_TMP);
            5'd20: u = bti_uop(SRC_W0,  SRC_T0X, 1'b1, 1'b0, 1'b0, DST_T0);
            5'd21: u = bti_uop(SRC_U1,  SRC_T1X, 1'b0, 1'b0, 1'b0, DST_T0);
            5'd22: u = bti_uop(SRC_U2,  SRC_T2X, 1'b0, 1'b0, 1'b1, DST_T0);
            5'd23: u = bti_uop(SRC_W0,  SRC_T0Y, 1'b1, 1'b0, 1'b0, DST_T1);
            5'd24: u = bti_uop(SRC_U1,  SRC_T1Y, 1'b0, 1'b0, 1'b0, DST_T1);
            5'd25: u = bti_uop(SRC_U2,  SRC_T2Y, 1'b0, 1'b0, 1'b1, DST_T1);
            5'd26: u = bti_uop(SRC_W0,  SRC_T0Z, 1'b1, 1'b0, 1'b0, DST_T2);
            5'd27: u = bti_uop(SRC_U1,  SRC_T1Z, 1'b0, 1'b0, 1'b0, DST_T2);
            5'd28: u = bti_uop(SRC_U2,  SRC_T2Z, 1'b0, 1'b0, 1'b1, DST_T2);
            default: u = bti_uop(SRC_U2, SRC_T2Z, 1'b1, 1'b0, 1'b1, DST_TMP);
        endcase
        return u;
    endfunction

endpackage

### design/bti_fifo.sv
module bti_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // two-entry queue between classification and execution
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### design/bti_front.sv
module bti_front #(
    parameter int COORD_WIDTH = bti_pkg::DEF_COORD_WIDTH
) (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [3*32-1:0]          s_tdata,
    input  logic [2:0]               s_tuser,
    input  logic                     q_full,
    output logic                     q_push,
    output bti_pkg::bti_cls_t        q_cls,
    output logic [3*COORD_WIDTH-1:0] q_payload
);

    localparam int W  = COORD_WIDTH;
    localparam int EW = W + 32;
    localparam logic signed [EW-1:0] C_MAX = {{33{1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] C_MIN = {{33{1'b1}}, {(W-1){1'b0}}};

    logic keep;

    // bring a 32-bit field into the internal range
    function automatic logic [W-1:0] sat_in(input logic signed [31:0] x);
        logic signed [EW-1:0] e;
        e = EW'(x);
        if (e > C_MAX) begin
            e = C_MAX;
        end else if (e < C_MIN) begin
            e = C_MIN;
        end
        return e[W-1:0];
    endfunction

    // classify op: corner load, texcoord load, query, or dropped
    always_comb begin
        keep        = 1'b1;
        q_cls.kind  = bti_pkg::KIND_QUERY;
        q_cls.idx   = 2'd0;
        if (s_tuser inside {[bti_pkg::OP_CORNER0:bti_pkg::OP_CORNER2]}) begin
            q_cls.kind = bti_pkg::KIND_CORNER;
            q_cls.idx  = s_tuser[1:0];
        end else if (s_tuser inside {[bti_pkg::OP_TEX0:bti_pkg::OP_TEX2]}) begin
            q_cls.kind = bti_pkg::KIND_TEX;
            q_cls.idx  = 2'(s_tuser - bti_pkg::OP_TEX0);
        end else if (s_tuser != bti_pkg::OP_QUERY) begin
            keep = 1'b0;
        end
    end

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full && keep;
    assign q_payload = {sat_in(s_tdata[95:64]), sat_in(s_tdata[63:32]), sat_in(s_tdata[31:0])};

endmodule

### design/bti_back.sv
module bti_back #(
    parameter int FRAC_BITS   = bti_pkg::DEF_FRAC_BITS,
    parameter int COORD_WIDTH = bti_pkg::DEF_COORD_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tex_en,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  bti_pkg::bti_cls_t        q_cls,
    input  logic [3*COORD_WIDTH-1:0] q_payload,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [95:0]              m_tdata,
    output logic [0:0]               m_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int AW  = W + 3;
    localparam int PW  = 2 * W;
    localparam int NCH = (W + 15) / 16;
    localparam int YW  = NCH * 16;
    localparam int DW  = W + F;
    localparam int DCW = $clog2(DW + 1);
    localparam int MCW = $clog2(NCH + 1);
    localparam int EW  = W + 32;

    localparam logic signed [AW-1:0] VMAX_A = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] VMIN_A = {4'b1111, {(W-1){1'b0}}};
    localparam logic signed [AW-1:0] ONE_A  = (F <= W - 2) ? (AW'(1) << F) : VMAX_A;
    localparam logic [PW-1:0] PLIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [PW-1:0] PLIM_NEG = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [DW-1:0] DLIM_POS = {{(F+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [DW-1:0] DLIM_NEG = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic signed [EW-1:0] O_MAX = EW'(32'sh7FFF_FFFF);
    localparam logic signed [EW-1:0] O_MIN = EW'(32'sh8000_0000);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MLD  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MFIN = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_DFIN = 4'd6;
    localparam logic [3:0] S_U1N  = 4'd7;
    localparam logic [3:0] S_W0   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]  state_reg;
    logic [4:0]  step_reg;
    logic        mv_reg;
    logic [95:0] mdata_reg;
    logic        muser_reg;

    // triangle stores
    logic signed [W-1:0] corner_reg [9];
    logic signed [W-1:0] tex_reg [9];

    // working values
    logic signed [W-1:0] b1_reg [3];
    logic signed [W-1:0] b2_reg [3];
    logic signed [W-1:0] v_reg [3];
    logic signed [W-1:0] d12_reg, l1_reg, l2_reg, dv1_reg, dv2_reg;
    logic signed [W-1:0] num_reg, den_reg, tmp_reg, u1_reg, u2_reg, w0_reg;
    logic signed [W-1:0] t_reg [3];
    logic                deg_reg;

    // shared multiplier
    logic [W-1:0]   mx_reg;
    logic [YW-1:0]  my_reg;
    logic [PW-1:0]  prod_reg;
    logic           mneg_reg;
    logic [MCW-1:0] mcnt_reg;
    logic signed [AW-1:0] acc_reg;

    // bit-serial divider
    logic [DW-1:0]  dn_reg;
    logic [W-1:0]   dd_reg;
    logic [W-1:0]   rem_reg;
    logic [DW-1:0]  quo_reg;
    logic           dneg_reg;
    logic           dsel_reg;
    logic [DCW-1:0] dcnt_reg;

    bti_pkg::bti_uop_t uop;
    logic signed [W-1:0] opa, opb;
    logic [W+15:0]       pp;
    logic [PW-1:0]       prod_next;
    logic [PW-1:0]       psh, plim, pm;
    logic signed [W-1:0] mres;
    logic signed [AW-1:0] acc_next;
    logic signed [W-1:0] acc_sat;
    logic [W:0]          r2;
    logic                ge;
    logic [W-1:0]        rem_next;
    logic [DW-1:0]       dlim, dm;
    logic signed [W-1:0] dres;
    logic signed [W-1:0] p_in [3];
    logic [3:0]          base;
    logic signed [W-1:0] u1n;

    function automatic logic signed [W-1:0] satw(input logic signed [AW-1:0] x);
        if (x > VMAX_A) begin
            return VMAX_A[W-1:0];
        end else if (x < VMIN_A) begin
            return VMIN_A[W-1:0];
        end
        return x[W-1:0];
    endfunction

    function automatic logic [W-1:0] magw(input logic signed [W-1:0] x);
        logic [W-1:0] u;
        u = x;
        return x[W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic [31:0] out32(input logic signed [W-1:0] x);
        logic signed [EW-1:0] e;
        e = EW'(x);
        if (e > O_MAX) begin
            e = O_MAX;
        end else if (e < O_MIN) begin
            e = O_MIN;
        end
        return e[31:0];
    endfunction

    function automatic logic signed [W-1:0] pick(input logic [4:0] code);
        logic signed [W-1:0] r;
        case (code)
            bti_pkg::SRC_B1X: r = b1_reg[0];
            bti_pkg::SRC_B1Y: r = b1_reg[1];
            bti_pkg::SRC_B1Z: r = b1_reg[2];
            bti_pkg::SRC_B2X: r = b2_reg[0];
            bti_pkg::SRC_B2Y: r = b2_reg[1];
            bti_pkg::SRC_B2Z: r = b2_reg[2];
            bti_pkg::SRC_VX:  r = v_reg[0];
            bti_pkg::SRC_VY:  r = v_reg[1];
            bti_pkg::SRC_VZ:  r = v_reg[2];
            bti_pkg::SRC_D12: r = d12_reg;
            bti_pkg::SRC_L1:  r = l1_reg;
            bti_pkg::SRC_L2:  r = l2_reg;
            bti_pkg::SRC_DV1: r = dv1_reg;
            bti_pkg::SRC_DV2: r = dv2_reg;
            bti_pkg::SRC_U1:  r = u1_reg;
            bti_pkg::SRC_U2:  r = u2_reg;
            bti_pkg::SRC_W0:  r = w0_reg;
            bti_pkg::SRC_T0X: r = tex_reg[0];
            bti_pkg::SRC_T0Y: r = tex_reg[1];
            bti_pkg::SRC_T0Z: r = tex_reg[2];
            bti_pkg::SRC_T1X: r = tex_reg[3];
            bti_pkg::SRC_T1Y: r = tex_reg[4];
            bti_pkg::SRC_T1Z: r = tex_reg[5];
            bti_pkg::SRC_T2X: r = tex_reg[6];
            bti_pkg::SRC_T2Y: r = tex_reg[7];
            bti_pkg::SRC_T2Z: r = tex_reg[8];
            default:          r = '0;
        endcase
        return r;
    endfunction

    // operand selection and multiplier datapath
    always_comb begin
        uop       = bti_pkg::bti_prog(step_reg);
        opa       = pick(uop.src_a);
        opb       = pick(uop.src_b);
        pp        = mx_reg * my_reg[YW-1 -: 16];
        prod_next = ((mcnt_reg == '0) ? '0 : (prod_reg << 16)) + PW'(pp);
        psh       = prod_reg >> F;
        plim      = mneg_reg ? PLIM_NEG : PLIM_POS;
        pm        = (psh > plim) ? plim : psh;
        mres      = mneg_reg ? (~pm[W-1:0] + 1'b1) : pm[W-1:0];
        acc_next  = (uop.first ? '0 : acc_reg) + (uop.neg ? -AW'(mres) : AW'(mres));
        acc_sat   = satw(acc_next);
    end

    // divider datapath: one quotient bit per cycle
    always_comb begin
        r2       = {rem_reg, dn_reg[DW-1]};
        ge       = (r2 >= {1'b0, dd_reg});
        rem_next = ge ? W'(r2 - {1'b0, dd_reg}) : r2[W-1:0];
        dlim     = dneg_reg ? DLIM_NEG : DLIM_POS;
        dm       = (quo_reg > dlim) ? dlim : quo_reg;
        dres     = dneg_reg ? (~dm[W-1:0] + 1'b1) : dm[W-1:0];
    end

    // queue head fields and misc arithmetic
    always_comb begin
        p_in[0] = q_payload[W-1:0];
        p_in[1] = q_payload[2*W-1:W];
        p_in[2] = q_payload[3*W-1:2*W];
        base    = {1'b0, q_cls.idx, 1'b0} + {2'b00, q_cls.idx};
        u1n     = satw(AW'(dv1_reg) - AW'(tmp_reg));
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            // result taken; S_OUT reloads the register itself
            if (mv_reg && m_tready && state_reg != S_OUT) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        case (q_cls.kind)
                            bti_pkg::KIND_CORNER: begin
                                for (int c = 0; c < 3; c++) begin
                                    corner_reg[base + 4'(c)] <= p_in[c];
                                end
                            end
                            bti_pkg::KIND_TEX: begin
                                for (int c = 0; c < 3; c++) begin
                                    tex_reg[base + 4'(c)] <= p_in[c];
                                end
                            end
                            default: begin
                                // edges and offset from corner 0
                                for (int c = 0; c < 3; c++) begin
                                    b1_reg[c] <= satw(AW'(corner_reg[3+c]) - AW'(corner_reg[c]));
                                    b2_reg[c] <= satw(AW'(corner_reg[6+c]) - AW'(corner_reg[c]));
                                    v_reg[c]  <= satw(AW'(p_in[c]) - AW'(corner_reg[c]));
                                end
                                step_reg <= '0;
                                if (tex_en) begin
                                    state_reg <= S_MLD;
                                end else begin
                                    for (int c = 0; c < 3; c++) begin
                                        t_reg[c] <= '0;
                                    end
                                    deg_reg   <= 1'b0;
                                    state_reg <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_MLD: begin
                    mx_reg    <= magw(opa);
                    my_reg    <= YW'(magw(opb));
                    mneg_reg  <= opa[W-1] ^ opb[W-1];
                    mcnt_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg <= prod_next;
                    my_reg   <= my_reg << 16;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == MCW'(NCH - 1)) begin
                        state_reg <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    acc_reg <= acc_next;
                    if (uop.last) begin
                        case (uop.dest)
                            bti_pkg::DST_D12: d12_reg  <= acc_sat;
                            bti_pkg::DST_L1:  l1_reg   <= acc_sat;
                            bti_pkg::DST_L2:  l2_reg   <= acc_sat;
                            bti_pkg::DST_DV1: dv1_reg  <= acc_sat;
                            bti_pkg::DST_DV2: dv2_reg  <= acc_sat;
                            bti_pkg::DST_NUM: num_reg  <= acc_sat;
                            bti_pkg::DST_DEN: den_reg  <= acc_sat;
                            bti_pkg::DST_T0:  t_reg[0] <= acc_sat;
                            bti_pkg::DST_T1:  t_reg[1] <= acc_sat;
                            bti_pkg::DST_T2:  t_reg[2] <= acc_sat;
                            default:          tmp_reg  <= acc_sat;
                        endcase
                    end
                    if (step_reg == bti_pkg::STEP_DEN_LAST) begin
                        state_reg <= S_CHK;
                    end else if (step_reg == bti_pkg::STEP_U2D12) begin
                        state_reg <= S_U1N;
                    end else if (step_reg == bti_pkg::STEP_LAST) begin
                        deg_reg   <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_MLD;
                    end
                end
                S_CHK: begin
                    if (den_reg == '0 || l1_reg == '0) begin
                        for (int c = 0; c < 3; c++) begin
                            t_reg[c] <= '0;
                        end
                        deg_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        // u2 = num / den
                        dn_reg    <= {magw(num_reg), {F{1'b0}}};
                        dd_reg    <= magw(den_reg);
                        dneg_reg  <= num_reg[W-1] ^ den_reg[W-1];
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        dsel_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_U1N: begin
                    // u1 = (dv1 - u2*d12) / l1
                    dn_reg    <= {magw(u1n), {F{1'b0}}};
                    dd_reg    <= magw(l1_reg);
                    dneg_reg  <= u1n[W-1] ^ l1_reg[W-1];
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    dsel_reg  <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= {quo_reg[DW-2:0], ge};
                    dn_reg   <= dn_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCW'(DW - 1)) begin
                        state_reg <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (!dsel_reg) begin
                        u2_reg    <= dres;
                        step_reg  <= bti_pkg::STEP_U2D12;
                        state_reg <= S_MLD;
                    end else begin
                        u1_reg    <= dres;
                        state_reg <= S_W0;
                    end
                end
                S_W0: begin
                    w0_reg    <= satw(ONE_A - AW'(u1_reg) - AW'(u2_reg));
                    step_reg  <= bti_pkg::STEP_TEX_FIRST;
                    state_reg <= S_MLD;
                end
                S_OUT: begin
                    if (!mv_reg || m_tready) begin
                        mdata_reg <= {out32(t_reg[2]), out32(t_reg[1]), out32(t_reg[0])};
                        muser_reg <= deg_reg;
                        mv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/barycentric_texcoord_interp_top.sv
// Barycentric texture-coordinate interpolator. Load transfers (op 0-2 on
// s_tuser) store a triangle corner, op 3-5 store a texture coordinate, op 6
// queries a hit position and returns one result: the interpolated texture
// coordinate on m_tdata and a degenerate flag on m_tuser. Stores are not
// cleared by reset; load all six items before the first query. A query is
// computed by the one shared 16-bit-slice multiplier and the bit-serial
// divider. Queries on a degenerate triangle or with texturing off finish
// early. A two-entry queue lets loads and queries be taken while a query is
// in progress. tex_enabled is to be written by the user only while the block
// is idle; the block itself does not enforce this.
module barycentric_texcoord_interp_top #(
    parameter int FRAC_BITS   = bti_pkg::DEF_FRAC_BITS,
    parameter int COORD_WIDTH = bti_pkg::DEF_COORD_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_coord, y_coord, z_coord
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // tex_u, tex_v, tex_w
    output logic [0:0]  m_tuser,   // degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // tex_enabled
);

    localparam int QW = $bits(bti_pkg::bti_cls_t) + 3 * COORD_WIDTH;

    logic                     tex_en_reg;
    logic                     q_full, q_push, q_pop, q_valid;
    bti_pkg::bti_cls_t        f_cls, b_cls;
    logic [3*COORD_WIDTH-1:0] f_payload, b_payload;
    logic [QW-1:0]            q_out;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            tex_en_reg <= cfg_data[0];
        end
    end

    bti_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cls    (f_cls),
        .q_payload(f_payload)
    );

    bti_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({f_cls, f_payload}),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_out)
    );

    assign b_cls     = q_out[QW-1 -: $bits(bti_pkg::bti_cls_t)];
    assign b_payload = q_out[3*COORD_WIDTH-1:0];

    bti_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tex_en   (tex_en_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cls    (b_cls),
        .q_payload(b_payload),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### design/bti_chk.sv
`include "barycentric_texcoord_interp_top_assert.svh"

module bti_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result stays offered
    `BTI_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `BTI_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // a degenerate triangle reports zeros
    `BTI_ASSERT_NOW(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 96'd0, "degenerate result not zero")

    // no result right after reset release
    `BTI_ASSERT_NOW(a_reset_quiet, aclk, aresetn, $past(!aresetn), !m_tvalid, "result offered out of reset")

endmodule

bind barycentric_texcoord_interp_top bti_chk u_chk (.*);
